// ----- design/bes_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the black edge smoothing filter.
// No dependencies; every other design file refers to it by scoped names.
package bes_pkg;

  // Sizes
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;
  localparam int ROW_W         = 12;   // row position, 0..MAX_HEIGHT-1
  localparam int HGT_W         = 13;   // row count, up to MAX_HEIGHT
  localparam int CFG_W_W       = 11;   // image_width register
  localparam int CFG_H_W       = 13;   // image_height register
  localparam int ADDR_W        = 3;    // configuration byte address
  localparam int QUEUE_DEPTH   = 4;    // jobs between front and back

  // Register reset values
  localparam logic [CFG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [CFG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd480;

  // Register map, indexed by byte address bit 2
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } bes_reg_t;

  // Input item kinds
  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } bes_req_t;

  // Pixel as stored in the line buffer, alpha in the top byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bes_pix_t;

  localparam bes_pix_t BLACK_PIX = 32'hFF00_0000;
  localparam logic [7:0] OPAQUE   = 8'd255;
  localparam logic [7:0] GRAY_TWO   = 8'd74;
  localparam logic [7:0] GRAY_THREE = 8'd34;
  localparam logic [7:0] GRAY_FOUR  = 8'd0;

  // Input channel payload
  typedef struct packed {
    bes_req_t   req_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } bes_in_t;

  // Result channel payload
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_end;
  } bes_out_t;

  // One emit job handed from front to back
  typedef struct packed {
    bes_pix_t pix;
    logic     above_en;   // row above exists
    logic     left_en;    // column to the left exists
    logic     right_hit;  // right neighbor is pending and black
    logic     down;       // pixel below is black
    logic     frame_end;
  } bes_job_t;

  // Back-end status seen by the front and the top level
  typedef struct packed {
    logic clearing;   // flag memory clear in progress
    logic b1_valid;   // job held in the back stage
  } bes_bstat_t;

  function automatic logic bes_is_black(input bes_pix_t p);
    return p == BLACK_PIX;
  endfunction

  // Gray level for a count of black neighbors of two or more
  function automatic logic [7:0] bes_gray(input logic [2:0] n);
    logic [7:0] g;
    case (n)
      3'd2:    g = GRAY_TWO;
      3'd3:    g = GRAY_THREE;
      default: g = GRAY_FOUR;
    endcase
    return g;
  endfunction

endpackage

// ----- design/bes_cfg.sv -----
`timescale 1ns / 1ps
// Configuration registers behind the APB-style port, and the clamped frame size.
// Depends on bes_pkg.
module bes_cfg #(
  parameter int MAX_WIDTH = bes_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [bes_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready,
  output logic [$clog2(MAX_WIDTH):0]   w_eff,
  output logic [bes_pkg::HGT_W-1:0]    h_eff
);

  localparam int WW = $clog2(MAX_WIDTH) + 1;
  localparam int LW = (WW > bes_pkg::CFG_W_W) ? WW : bes_pkg::CFG_W_W;
  localparam int HW = bes_pkg::HGT_W;

  logic [bes_pkg::CFG_W_W-1:0] width_r;
  logic [bes_pkg::CFG_H_W-1:0] height_r;
  logic                        wr_en;
  bes_pkg::bes_reg_t           reg_sel;
  logic [LW-1:0]               w_raw;
  logic [LW-1:0]               w_clamp;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = bes_pkg::bes_reg_t'(cfg_paddr[2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bes_pkg::IMAGE_WIDTH_RST;
      height_r <= bes_pkg::IMAGE_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        bes_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_pwdata[bes_pkg::CFG_W_W-1:0];
        bes_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_pwdata[bes_pkg::CFG_H_W-1:0];
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_sel)
      bes_pkg::REG_IMAGE_WIDTH:  cfg_prdata = 32'(width_r);
      bes_pkg::REG_IMAGE_HEIGHT: cfg_prdata = 32'(height_r);
    endcase
  end

  // Clamp width to 1..MAX_WIDTH
  always_comb begin
    w_raw = LW'(width_r);
    if (w_raw == '0) begin
      w_clamp = LW'(1);
    end else if (w_raw > LW'(MAX_WIDTH)) begin
      w_clamp = LW'(MAX_WIDTH);
    end else begin
      w_clamp = w_raw;
    end
    w_eff = w_clamp[WW-1:0];
  end

  // Clamp height to 1..MAX_HEIGHT
  always_comb begin
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (height_r > HW'(bes_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(bes_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

endmodule

// ----- design/bes_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts pixels and drain ticks, tracks positions, owns the line
// buffer and classifies each item into an emit job. Depends on bes_pkg.
module bes_front #(
  parameter int MAX_WIDTH = bes_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [$clog2(MAX_WIDTH):0]  w_eff,
  input  logic [bes_pkg::HGT_W-1:0]   h_eff,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bes_pkg::bes_in_t            in_data,
  input  bes_pkg::bes_bstat_t         bstat,
  input  logic                        q_full,
  output logic                        push_valid,
  output logic [$clog2(MAX_WIDTH)-1:0] push_col,
  output bes_pkg::bes_job_t           push_job
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int HW = bes_pkg::HGT_W;
  localparam int RW = bes_pkg::ROW_W;

  // Position state
  logic [CW-1:0] in_col_r;
  logic [CW-1:0] out_col_r;
  logic [RW-1:0] out_row_r;
  logic [WW-1:0] pcount_r;

  // Line buffer and its read registers
  bes_pkg::bes_pix_t line_mem [MAX_WIDTH];
  bes_pkg::bes_pix_t rd_cur_r;
  bes_pkg::bes_pix_t rd_right_r;

  // Classification stage
  logic          f1_valid_r;
  logic [CW-1:0] f1_col_r;
  logic          f1_above_r;
  logic          f1_left_r;
  logic          f1_right_en_r;
  logic          f1_down_r;
  logic          f1_fe_r;

  logic              accept;
  logic              f1_free;
  logic              is_pixel;
  bes_pkg::bes_pix_t px;
  logic [CW-1:0]     ic;
  logic [CW-1:0]     oc;
  logic [RW-1:0]     orow;
  logic [WW-1:0]     pc;
  logic [WW-1:0]     ic_p1;
  logic [WW-1:0]     oc_p1;
  logic [HW-1:0]     orow_p1;
  logic [CW-1:0]     ic_nxt;
  logic [CW-1:0]     oc_nxt;
  logic [RW-1:0]     orow_nxt;
  logic [WW-1:0]     pc_nxt;
  logic [CW-1:0]     right_addr;
  logic              last_row;
  logic              emit;
  logic              down;
  logic              right_en;
  logic              frame_end;

  // Take a new item whenever the classification stage can move on and no flag clear is in progress
  assign f1_free  = !f1_valid_r || !q_full;
  assign in_ready = !bstat.clearing && f1_free;
  assign accept   = in_valid && in_ready;

  // Classify the item against the wrapped positions
  always_comb begin
    is_pixel = (in_data.req_type == bes_pkg::REQ_PIXEL);
    px       = {in_data.in_alpha, in_data.in_blue, in_data.in_green, in_data.in_red};

    ic   = (WW'(in_col_r) >= w_eff) ? '0 : in_col_r;
    oc   = (WW'(out_col_r) >= w_eff) ? '0 : out_col_r;
    orow = (HW'(out_row_r) >= h_eff) ? '0 : out_row_r;
    pc   = (pcount_r > w_eff) ? w_eff : pcount_r;

    last_row = (HW'(orow) == (h_eff - HW'(1)));
    ic_p1    = WW'(ic) + WW'(1);
    oc_p1    = WW'(oc) + WW'(1);
    orow_p1  = HW'(orow) + HW'(1);

    if (is_pixel) begin
      emit = (pc == w_eff);
    end else begin
      emit = (pc != '0) && last_row;
    end
    down      = is_pixel && !last_row && bes_pkg::bes_is_black(px);
    right_en  = (oc_p1 < w_eff) && (pc >= WW'(2));
    frame_end = last_row && (oc_p1 == w_eff);
    right_addr = (oc_p1 < w_eff) ? oc_p1[CW-1:0] : oc;

    // Advance positions
    ic_nxt   = (ic_p1 >= w_eff) ? '0 : ic_p1[CW-1:0];
    oc_nxt   = (oc_p1 >= w_eff) ? '0 : oc_p1[CW-1:0];
    if (oc_p1 >= w_eff) begin
      orow_nxt = (orow_p1 >= h_eff) ? '0 : orow_p1[RW-1:0];
    end else begin
      orow_nxt = orow;
    end

    if (is_pixel && !emit) begin
      pc_nxt = pc + WW'(1);
    end else if (!is_pixel && emit) begin
      pc_nxt = pc - WW'(1);
    end else begin
      pc_nxt = pc;
    end
  end

  // Position registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pcount_r  <= '0;
    end else if (accept) begin
      in_col_r  <= is_pixel ? ic_nxt : ic;
      out_col_r <= emit ? oc_nxt : oc;
      out_row_r <= emit ? orow_nxt : orow;
      pcount_r  <= pc_nxt;
    end
  end

  // Line buffer: reads see the contents before this item's write
  always_ff @(posedge clk) begin
    if (accept && is_pixel) begin
      line_mem[ic] <= px;
    end
    if (accept && emit) begin
      rd_cur_r   <= line_mem[oc];
      rd_right_r <= line_mem[right_addr];
    end
  end

  // Classification stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (accept && emit) begin
      f1_valid_r <= 1'b1;
    end else if (f1_free) begin
      f1_valid_r <= 1'b0;
    end
  end

  // Classification stage payload
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      f1_col_r      <= oc;
      f1_above_r    <= (orow != '0);
      f1_left_r     <= (oc != '0);
      f1_right_en_r <= right_en;
      f1_down_r     <= down;
      f1_fe_r       <= frame_end;
    end
  end

  // Hand the job to the queue
  always_comb begin
    push_valid         = f1_valid_r;
    push_col           = f1_col_r;
    push_job.pix       = rd_cur_r;
    push_job.above_en  = f1_above_r;
    push_job.left_en   = f1_left_r;
    push_job.right_hit = f1_right_en_r && bes_pkg::bes_is_black(rd_right_r);
    push_job.down      = f1_down_r;
    push_job.frame_end = f1_fe_r;
  end

endmodule

// ----- design/bes_queue.sv -----
`timescale 1ns / 1ps
// Short job queue that decouples the front end from the back end.
// Depends on bes_pkg.
module bes_queue #(
  parameter int COL_W = $clog2(bes_pkg::MAX_WIDTH_DEF)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  logic [COL_W-1:0]  push_col,
  input  bes_pkg::bes_job_t push_job,
  output logic              full,
  output logic              pop_valid,
  output logic [COL_W-1:0]  pop_col,
  output bes_pkg::bes_job_t pop_job,
  input  logic              pop
);

  localparam int DEPTH = bes_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [COL_W-1:0]  col_q [DEPTH];
  bes_pkg::bes_job_t job_q [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [NW-1:0]     count_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == NW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;
  assign pop_col   = col_q[rd_ptr_r];
  assign pop_job   = job_q[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      col_q[wr_ptr_r] <= push_col;
      job_q[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + NW'(1);
      end else if (!do_push && do_pop) begin
        count_r <= count_r - NW'(1);
      end
    end
  end

endmodule

// ----- design/bes_back.sv -----
`timescale 1ns / 1ps
// Back end: looks up the above-row black flags, counts black neighbors,
// replaces edge pixels by gray and holds the result register. Depends on bes_pkg.
module bes_back #(
  parameter int MAX_WIDTH = bes_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  input  bes_pkg::bes_job_t            q_job,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bes_pkg::bes_out_t            out_data,
  output bes_pkg::bes_bstat_t          bstat
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [CW-1:0] LAST_COL = CW'(MAX_WIDTH - 1);

  // Black flags of the last emitted row
  logic              flag_mem [MAX_WIDTH];
  logic              flag_q_r;
  logic              fwd_hit_r;
  logic              fwd_val_r;

  logic              clearing_r;
  logic [CW-1:0]     clr_idx_r;

  logic              b1_valid_r;
  logic [CW-1:0]     b1_col_r;
  bes_pkg::bes_job_t b1_job_r;
  logic              left_black_r;

  logic              out_valid_r;
  bes_pkg::bes_out_t out_data_r;

  logic              b1_move;
  logic              above;
  logic              blk;
  logic [2:0]        n_black;
  logic [7:0]        gray;
  bes_pkg::bes_out_t res;
  logic              fl_we;
  logic [CW-1:0]     fl_wa;
  logic              fl_wd;

  assign b1_move   = b1_valid_r && (!out_valid_r || out_ready);
  assign q_pop     = q_valid && !clearing_r && (!b1_valid_r || b1_move);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign bstat.clearing = clearing_r;
  assign bstat.b1_valid = b1_valid_r;

  // Count black neighbors and pick the result
  always_comb begin
    above   = fwd_hit_r ? fwd_val_r : flag_q_r;
    blk     = bes_pkg::bes_is_black(b1_job_r.pix);
    n_black = 3'(b1_job_r.above_en && above) + 3'(b1_job_r.left_en && left_black_r)
            + 3'(b1_job_r.right_hit) + 3'(b1_job_r.down);
    gray    = bes_pkg::bes_gray(n_black);
    res.frame_end = b1_job_r.frame_end;
    if (!blk && (n_black >= 3'd2)) begin
      res.out_red   = gray;
      res.out_green = gray;
      res.out_blue  = gray;
      res.out_alpha = bes_pkg::OPAQUE;
    end else begin
      res.out_red   = b1_job_r.pix.red;
      res.out_green = b1_job_r.pix.green;
      res.out_blue  = b1_job_r.pix.blue;
      res.out_alpha = b1_job_r.pix.alpha;
    end
  end

  // Flag write port: clearing sweep or the emitted pixel's flag
  always_comb begin
    fl_we = clearing_r || b1_move;
    fl_wa = clearing_r ? clr_idx_r : b1_col_r;
    fl_wd = clearing_r ? 1'b0 : blk;
  end

  // Flag memory
  always_ff @(posedge clk) begin
    if (fl_we) begin
      flag_mem[fl_wa] <= fl_wd;
    end
    if (q_pop) begin
      flag_q_r <= flag_mem[q_col];
    end
  end

  // Clear the flag memory after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + CW'(1);
      if (clr_idx_r == LAST_COL) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Back stage: forward the flag written at the same edge as the lookup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r   <= 1'b0;
      fwd_hit_r    <= 1'b0;
      fwd_val_r    <= 1'b0;
      left_black_r <= 1'b0;
    end else begin
      if (q_pop) begin
        b1_valid_r <= 1'b1;
        fwd_hit_r  <= b1_move && (b1_col_r == q_col);
        fwd_val_r  <= blk;
      end else if (b1_move) begin
        b1_valid_r <= 1'b0;
      end
      if (b1_move) begin
        left_black_r <= blk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b1_col_r <= q_col;
      b1_job_r <= q_job;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_move) begin
      out_data_r <= res;
    end
  end

endmodule

// ----- design/black_edge_smoothing_filter.sv -----
`timescale 1ns / 1ps
// Top level of the black edge smoothing filter: configuration registers,
// front end, job queue and back end. Depends on bes_pkg and the bes_ modules.
//
// The filter takes one transfer per clock, pixel or drain tick, while in_ready
// is high, and can hand out one result per clock. A pixel's result leaves only
// once the pixel below it has arrived, so it trails its own input by one image
// row. The line buffer is read at the edge that accepts the item below; the job
// then passes the queue and the flag lookup before the result register is
// loaded. The line buffer does one write and two reads per cycle, and the flags
// of the row above sit in a one-read, one-write memory in the back end. After
// reset the flag memory is cleared entry by entry; in_ready stays low for that
// time while the configuration port works as usual. Send drain ticks after the
// last pixel of a frame to flush its last row, one result per tick.
module black_edge_smoothing_filter #(
  parameter int MAX_WIDTH = bes_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bes_pkg::bes_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bes_pkg::bes_out_t          out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [bes_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  logic [WW-1:0]              w_eff;
  logic [bes_pkg::HGT_W-1:0]  h_eff;
  logic                       push_valid;
  logic [CW-1:0]              push_col;
  bes_pkg::bes_job_t          push_job;
  logic                       q_full;
  logic                       q_valid;
  logic [CW-1:0]              q_col;
  bes_pkg::bes_job_t          q_job;
  logic                       q_pop;
  bes_pkg::bes_bstat_t        bstat;

  bes_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .w_eff       (w_eff),
    .h_eff       (h_eff)
  );

  bes_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .bstat      (bstat),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_col   (push_col),
    .push_job   (push_job)
  );

  bes_queue #(.COL_W(CW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_col   (push_col),
    .push_job   (push_job),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_col    (q_col),
    .pop_job    (q_job),
    .pop        (q_pop)
  );

  bes_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_col     (q_col),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .bstat     (bstat)
  );

  // No input transfer while the flag memory is being cleared
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.clearing |-> !in_ready)
    else $error("input taken during flag memory clear");

  // A queued job moves into an empty back stage at the next edge
  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !bstat.b1_valid) |=> bstat.b1_valid)
    else $error("queued job not taken by idle back stage");

  // A new result always comes from a job held in the back stage
  a_result_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bstat.b1_valid))
    else $error("result appeared without a job in the back stage");

  // The front never offers a job the queue cannot take while the queue is empty
  a_queue_not_full_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !q_full)
    else $error("queue reports full while empty");

endmodule

// ----- bench/tb_black_edge_smoothing_filter.sv -----
`timescale 1ns / 1ps
// Self-checking bench for black_edge_smoothing_filter: drives pixel and drain
// transfers, predicts every filtered pixel and checks the result channel.
// Depends on bes_pkg and the filter RTL.
module tb_black_edge_smoothing_filter;
  import bes_pkg::*;

  localparam int LINE_MAX      = MAX_WIDTH_DEF;
  localparam int ROWS_MAX      = MAX_HEIGHT;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS   = 10;

  localparam logic [7:0]  SHADE_TWO   = 8'd74;
  localparam logic [7:0]  SHADE_THREE = 8'd34;
  localparam logic [7:0]  SHADE_FOUR  = 8'd0;
  localparam logic [31:0] BLACK_WORD  = 32'hFF00_0000;
  localparam logic [31:0] WHITE_WORD  = 32'hFFFF_FFFF;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  bes_in_t           in_data     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  bes_out_t          out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  black_edge_smoothing_filter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Filter image of the bench: register copies, line store and positions
  logic [10:0] width_reg  = 11'd640;
  logic [12:0] height_reg = 13'd480;
  bit [31:0]   line_px [LINE_MAX];
  bit          above_blk [LINE_MAX];
  int unsigned col_in, row_in, col_out, row_out, pend_cnt;
  bit          left_blk;

  bes_out_t expected_px[$];
  int       mismatch_count = 0;
  bit       idling = 1'b1;
  int       hold_request = 0;
  int       hold_left = 0;
  int       stall_left = 0;
  int       quiet_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit is_black_word(logic [31:0] px);
    return px == BLACK_WORD;
  endfunction

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > LINE_MAX) return LINE_MAX;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > ROWS_MAX) return ROWS_MAX;
    return height_reg;
  endfunction

  function automatic void check_value(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t %s mismatch: expected %0h, actual %0h", $realtime, what, want, got);
    end
  endfunction

  // Release the pixel at the output position; down_blk is its lower neighbor
  function automatic void retire_pixel(bit down_blk, int unsigned w, int unsigned h);
    int unsigned c;
    logic [31:0] px;
    bit          blk;
    int unsigned n;
    logic [7:0]  shade;
    bes_out_t    res;
    c   = col_out;
    px  = line_px[c];
    blk = is_black_word(px);
    n   = 0;
    if (row_out > 0 && above_blk[c]) n++;
    if (c > 0 && left_blk) n++;
    if (c + 1 < w && pend_cnt >= 2 && is_black_word(line_px[c + 1])) n++;
    if (down_blk) n++;
    res.out_red   = px[7:0];
    res.out_green = px[15:8];
    res.out_blue  = px[23:16];
    res.out_alpha = px[31:24];
    if (!blk && n >= 2) begin
      shade = (n == 2) ? SHADE_TWO : (n == 3) ? SHADE_THREE : SHADE_FOUR;
      res.out_red   = shade;
      res.out_green = shade;
      res.out_blue  = shade;
      res.out_alpha = 8'hFF;
    end
    res.frame_end = (row_out == h - 1) && (c == w - 1);
    expected_px.push_back(res);
    left_blk     = blk;
    above_blk[c] = blk;
    pend_cnt--;
    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      row_out++;
      if (row_out >= h) row_out = 0;
    end
  endfunction

  // Advance the filter image by one accepted transfer
  function automatic void filter_predict(bes_in_t item);
    int unsigned w, h;
    logic [31:0] px;
    w = eff_width();
    h = eff_height();
    // wrap positions that lie beyond a new frame size
    if (col_in >= w) col_in = 0;
    if (col_out >= w) col_out = 0;
    if (row_in >= h) row_in = 0;
    if (row_out >= h) row_out = 0;
    if (pend_cnt > w) pend_cnt = w;
    if (item.req_type == REQ_DRAIN) begin
      if (pend_cnt > 0 && row_out == h - 1) retire_pixel(1'b0, w, h);
      return;
    end
    px = {item.in_alpha, item.in_blue, item.in_green, item.in_red};
    // full line store: release the oldest pixel, the new one lies below it
    if (pend_cnt >= w) retire_pixel((row_out + 1 < h) && is_black_word(px), w, h);
    line_px[col_in] = px;
    pend_cnt++;
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
      if (row_in >= h) row_in = 0;
    end
  endfunction

  function automatic bes_in_t make_pixel(logic [31:0] px);
    bes_in_t item;
    item.req_type = REQ_PIXEL;
    item.in_red   = px[7:0];
    item.in_green = px[15:8];
    item.in_blue  = px[23:16];
    item.in_alpha = px[31:24];
    return item;
  endfunction

  // Drain ticks carry random junk in the channel fields
  function automatic bes_in_t make_drain();
    bes_in_t item;
    item          = make_pixel($urandom);
    item.req_type = REQ_DRAIN;
    return item;
  endfunction

  // Nearly half black, some one bit away from black, some white, the rest anything
  function automatic logic [31:0] rand_pixel();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return BLACK_WORD;
    if (pick < 60) return BLACK_WORD ^ (32'd1 << $urandom_range(0, 31));
    if (pick < 65) return WHITE_WORD;
    return $urandom;
  endfunction

  // Offer one item and hold it until the transfer; called on a clock edge
  task automatic send_item(input bes_in_t item);
    int gap;
    gap = idling ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    filter_predict(item);
  endtask

  // One configuration access: setup cycle, then access cycle
  task automatic cfg_access(input bes_reg_t r, input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic check_register(input bes_reg_t r, input logic [31:0] want);
    logic [31:0] got;
    cfg_access(r, 1'b0, $urandom, got);
    check_value(r.name(), want, got);
  endtask

  // Write both size registers with junk in the unused bits, then read back
  task automatic set_frame_size(input int unsigned wreg, input int unsigned hreg);
    logic [31:0] unused;
    cfg_access(REG_IMAGE_WIDTH, 1'b1, ($urandom & 32'hFFFF_F800) | wreg, unused);
    width_reg = wreg[10:0];
    cfg_access(REG_IMAGE_HEIGHT, 1'b1, ($urandom & 32'hFFFF_E000) | hreg, unused);
    height_reg = hreg[12:0];
    check_register(REG_IMAGE_WIDTH, {21'd0, width_reg});
    check_register(REG_IMAGE_HEIGHT, {19'd0, height_reg});
  endtask

  // Drop valid, wait for every expected result, then let the pipe empty
  task automatic settle_results();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Feed pixels up to the last row, then drain ticks until nothing is stored
  task automatic flush_frame();
    while (pend_cnt > 0) begin
      if (row_out == eff_height() - 1) send_item(make_drain());
      else send_item(make_pixel(rand_pixel()));
    end
  endtask

  task automatic run_frames(input int unsigned wreg, input int unsigned hreg,
                            input int unsigned n_px);
    settle_results();
    set_frame_size(wreg, hreg);
    repeat (n_px) begin
      if ($urandom_range(0, 24) == 0) send_item(make_drain());
      else send_item(make_pixel(rand_pixel()));
    end
    flush_frame();
  endtask

  task automatic test_register_reset();
    check_register(REG_IMAGE_WIDTH, 32'd640);
    check_register(REG_IMAGE_HEIGHT, 32'd480);
  endtask

  // Hand-built 3x3 frames: black diamond round a white center, black checkerboard, near-black pixels
  task automatic test_directed_patterns();
    logic [31:0] grid_a [9];
    logic [31:0] grid_b [9];
    grid_a = '{WHITE_WORD, BLACK_WORD, WHITE_WORD,
               BLACK_WORD, WHITE_WORD, BLACK_WORD,
               WHITE_WORD, BLACK_WORD, WHITE_WORD};
    grid_b = '{BLACK_WORD, WHITE_WORD, BLACK_WORD,
               WHITE_WORD, BLACK_WORD, WHITE_WORD,
               32'h0000_0000, 32'hFE00_0000, 32'hFF00_0001};
    set_frame_size(3, 3);
    // drain tick with nothing stored
    send_item(make_drain());
    foreach (grid_a[i]) send_item(make_pixel(grid_a[i]));
    // next frame starts while the last row is still stored
    foreach (grid_b[i]) send_item(make_pixel(grid_b[i]));
    repeat (4) send_item(make_drain());
  endtask

  task automatic test_small_sizes();
    run_frames(0, 0, 40);
    run_frames(1, 12, 30);
    run_frames(9, 1, 50);
    run_frames(2, 2, 50);
    idling = 1'b0;
    run_frames(5, 4, 60);
    idling = 1'b1;
    run_frames(16, 6, 80);
    run_frames(33, 3, 80);
    // widest rows, single-row frames so drain ticks flush them
    run_frames(2047, 1, 40);
    run_frames(1024, 1, 30);
    for (int i = 0; i < 5; i++) begin
      idling = (i != 2);
      run_frames($urandom_range(1, 20), $urandom_range(1, 8), $urandom_range(50, 90));
    end
    idling = 1'b1;
  endtask

  // Hold off the receiver while the sender streams without gaps
  task automatic test_output_backpressure();
    settle_results();
    set_frame_size(4, 30);
    idling = 1'b0;
    hold_request = 400;
    repeat (120) send_item(make_pixel(rand_pixel()));
    idling = 1'b1;
    flush_frame();
  endtask

  // Largest frame, partly filled, then shrink it while pixels are stored
  task automatic test_large_frame();
    settle_results();
    set_frame_size(2047, 8191);
    repeat (1036) send_item(make_pixel(rand_pixel()));
    run_frames(5, 3, 40);
  endtask

  // Result side: check each transfer, then draw the stall before the next
  always @(posedge clk) begin : result_side
    bes_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_px.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t result with nothing expected: %h", $realtime, out_data);
      end else begin
        want = expected_px.pop_front();
        check_value("out_red", want.out_red, out_data.out_red);
        check_value("out_green", want.out_green, out_data.out_green);
        check_value("out_blue", want.out_blue, out_data.out_blue);
        check_value("out_alpha", want.out_alpha, out_data.out_alpha);
        check_value("frame_end", want.frame_end, out_data.frame_end);
      end
      stall_left = idling ? $urandom_range(0, 10) : 0;
    end
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_register_reset();
    test_directed_patterns();
    test_small_sizes();
    test_output_backpressure();
    test_large_frame();
    settle_results();
    if (mismatch_count == 0 && expected_px.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- black_edge_smoothing_filter.f -----
design/bes_pkg.sv
design/bes_cfg.sv
design/bes_front.sv
design/bes_queue.sv
design/bes_back.sv
design/black_edge_smoothing_filter.sv
bench/tb_black_edge_smoothing_filter.sv
